// File: hdl/rc4_page_descrambler_unit_defines.svh
// Assertion macros shared by the descrambler RTL.
`ifndef RC4_PAGE_DESCRAMBLER_UNIT_DEFINES_SVH
`define RC4_PAGE_DESCRAMBLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RC4PD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RC4PD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rc4pd_pkg.sv
// Shared types, constants and the microcode program of the descrambler.
package rc4pd_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);
    localparam int KEY_LEN    = 16;
    localparam int KEY_IW     = $clog2(KEY_LEN);
    localparam int STEP_W     = 5;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [PERM_AW-1:0] perm_addr_t;
    typedef logic [STEP_W-1:0]  step_t;

    localparam byte_t SCRAMBLE_KEY [KEY_LEN] = '{
        8'h7C, 8'h4E, 8'h03, 8'h04, 8'h55, 8'h05, 8'h09, 8'h07,
        8'h2D, 8'h2C, 8'h7B, 8'h38, 8'h17, 8'h0D, 8'h17, 8'h11
    };

    // Read address source
    typedef enum logic [1:0] {RA_I, RA_J, RA_SUM} rd_sel_t;
    // Write address source
    typedef enum logic {WA_I, WA_J} wa_sel_t;
    // Write data source
    typedef enum logic [1:0] {WD_I, WD_SI, WD_RD} wd_sel_t;
    typedef enum logic [1:0] {I_HOLD, I_INC, I_CLEAR} i_op_t;
    typedef enum logic [1:0] {J_HOLD, J_CLEAR, J_ADD_RD, J_ADD_KEY} j_op_t;
    // Jump condition; the jump is taken when it holds
    typedef enum logic [2:0] {
        C_NEVER, C_ALWAYS, C_NO_ACCEPT, C_NO_REKEY, C_I_NOT_LAST, C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        i_op_t   i_op;
        j_op_t   j_op;
        logic    ld_si;
        logic    ld_sj;
        logic    in_ready;
        logic    out_load;
        cond_t   cond;
        step_t   target;
    } ctrl_t;

    typedef struct packed {
        logic rekey;
        logic i_last;
    } dp_status_t;

    // Program steps
    localparam step_t ST_IDLE     = 5'd0;
    localparam step_t ST_DISPATCH = 5'd1;
    localparam step_t ST_CLEAR    = 5'd2;
    localparam step_t ST_FILL     = 5'd3;
    localparam step_t ST_K0       = 5'd4;
    localparam step_t ST_K1       = 5'd5;
    localparam step_t ST_K2       = 5'd6;
    localparam step_t ST_K3       = 5'd7;
    localparam step_t ST_K4       = 5'd8;
    localparam step_t ST_K5       = 5'd9;
    localparam step_t ST_P0       = 5'd10;
    localparam step_t ST_P1       = 5'd11;
    localparam step_t ST_P2       = 5'd12;
    localparam step_t ST_P3       = 5'd13;
    localparam step_t ST_P4       = 5'd14;
    localparam step_t ST_P5       = 5'd15;
    localparam step_t ST_P6       = 5'd16;
    localparam step_t ST_P7       = 5'd17;

    localparam ctrl_t CW_NOP = '{
        rd_sel: RA_I, wr_en: 1'b0, wa_sel: WA_I, wd_sel: WD_I,
        i_op: I_HOLD, j_op: J_HOLD, ld_si: 1'b0, ld_sj: 1'b0,
        in_ready: 1'b0, out_load: 1'b0, cond: C_NEVER, target: ST_IDLE
    };

    // Microcode ROM: one control word per step
    function automatic ctrl_t ucode(step_t pc);
        ctrl_t cw;
        cw = CW_NOP;
        unique case (pc)
            ST_IDLE:
            begin
                cw.in_ready = 1'b1;
                cw.cond     = C_NO_ACCEPT;
                cw.target   = ST_IDLE;
            end
            ST_DISPATCH:
            begin
                cw.cond   = C_NO_REKEY;
                cw.target = ST_P0;
            end
            ST_CLEAR:
            begin
                cw.i_op = I_CLEAR;
                cw.j_op = J_CLEAR;
            end
            ST_FILL:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_I;
                cw.wd_sel = WD_I;
                cw.i_op   = I_INC;
                cw.cond   = C_I_NOT_LAST;
                cw.target = ST_FILL;
            end
            ST_K0:
            begin
                cw.rd_sel = RA_I;
            end
            ST_K1:
            begin
                cw.ld_si = 1'b1;
                cw.j_op  = J_ADD_KEY;
            end
            ST_K2:
            begin
                cw.rd_sel = RA_J;
            end
            ST_K3:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_I;
                cw.wd_sel = WD_RD;
            end
            ST_K4:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_J;
                cw.wd_sel = WD_SI;
                cw.i_op   = I_INC;
                cw.cond   = C_I_NOT_LAST;
                cw.target = ST_K0;
            end
            ST_K5:
            begin
                cw.j_op = J_CLEAR;
            end
            ST_P0:
            begin
                cw.i_op = I_INC;
            end
            ST_P1:
            begin
                cw.rd_sel = RA_I;
            end
            ST_P2:
            begin
                cw.ld_si = 1'b1;
                cw.j_op  = J_ADD_RD;
            end
            ST_P3:
            begin
                cw.rd_sel = RA_J;
            end
            ST_P4:
            begin
                cw.ld_sj  = 1'b1;
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_I;
                cw.wd_sel = WD_RD;
            end
            ST_P5:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_J;
                cw.wd_sel = WD_SI;
            end
            ST_P6:
            begin
                // Keep reading the keystream byte while the output slot is busy
                cw.rd_sel = RA_SUM;
                cw.cond   = C_OUT_BUSY;
                cw.target = ST_P6;
            end
            ST_P7:
            begin
                cw.out_load = 1'b1;
                cw.cond     = C_ALWAYS;
                cw.target   = ST_IDLE;
            end
            default:
            begin
                cw.cond   = C_ALWAYS;
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// File: hdl/rc4pd_ifs.sv
// Input and output channel interfaces of the descrambler.
interface rc4pd_in_if;
    logic                      valid;
    logic                      ready;
    logic [rc4pd_pkg::BYTE_W-1:0] data_in;
    logic                      last_of_page;

    modport source (output valid, output data_in, output last_of_page, input ready);
    modport sink   (input valid, input data_in, input last_of_page, output ready);
endinterface

interface rc4pd_out_if;
    logic                      valid;
    logic                      ready;
    logic [rc4pd_pkg::BYTE_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// File: hdl/rc4pd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4pd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/rc4pd_sequencer.sv
// Step counter and microcode ROM that drive the descrambler datapath.
module rc4pd_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  out_busy,
    input  rc4pd_pkg::dp_status_t status,
    output rc4pd_pkg::ctrl_t      ctrl
);
    import rc4pd_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    ctrl_t cw;
    logic  jump;

    assign cw   = ucode(pc_reg);
    assign ctrl = cw;

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_ACCEPT:  jump = !accept;
            C_NO_REKEY:   jump = !status.rekey;
            C_I_NOT_LAST: jump = !status.i_last;
            C_OUT_BUSY:   jump = out_busy;
            default:      jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : step_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: hdl/rc4pd_datapath.sv
// Index registers, swap latches and permutation memory of the descrambler.
module rc4pd_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rc4pd_pkg::ctrl_t         ctrl,
    input  logic                     accept,
    input  logic [rc4pd_pkg::BYTE_W-1:0] data_in,
    input  logic                     last_of_page,
    output rc4pd_pkg::dp_status_t    status,
    output logic [rc4pd_pkg::BYTE_W-1:0] ks_data
);
    import rc4pd_pkg::*;

    byte_t      i_reg, i_next;
    byte_t      j_reg, j_next;
    byte_t      si_reg;
    byte_t      sj_reg;
    byte_t      din_reg;
    logic       last_reg;
    logic       rekey_reg;
    byte_t      rd_data;
    perm_addr_t rd_addr;
    perm_addr_t wr_addr;
    byte_t      wr_data;
    byte_t      key_byte;

    assign key_byte = SCRAMBLE_KEY[i_reg[KEY_IW-1:0]];

    always_comb
    begin
        unique case (ctrl.rd_sel)
            RA_I:    rd_addr = i_reg;
            RA_J:    rd_addr = j_reg;
            RA_SUM:  rd_addr = perm_addr_t'(si_reg + sj_reg);
            default: rd_addr = i_reg;
        endcase
        wr_addr = (ctrl.wa_sel == WA_J) ? j_reg : i_reg;
        unique case (ctrl.wd_sel)
            WD_I:    wr_data = i_reg;
            WD_SI:   wr_data = si_reg;
            WD_RD:   wr_data = rd_data;
            default: wr_data = rd_data;
        endcase
        unique case (ctrl.i_op)
            I_HOLD:  i_next = i_reg;
            I_INC:   i_next = byte_t'(i_reg + 1'b1);
            I_CLEAR: i_next = '0;
            default: i_next = i_reg;
        endcase
        unique case (ctrl.j_op)
            J_HOLD:    j_next = j_reg;
            J_CLEAR:   j_next = '0;
            J_ADD_RD:  j_next = byte_t'(j_reg + rd_data);
            J_ADD_KEY: j_next = byte_t'(j_reg + rd_data + key_byte);
            default:   j_next = j_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            rekey_reg <= 1'b1;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            if (ctrl.out_load)
            begin
                rekey_reg <= last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_si)
        begin
            si_reg <= rd_data;
        end
        if (ctrl.ld_sj)
        begin
            sj_reg <= rd_data;
        end
        if (accept)
        begin
            din_reg  <= data_in;
            last_reg <= last_of_page;
        end
    end

    rc4pd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status.rekey  = rekey_reg;
    assign status.i_last = (i_reg == byte_t'(PERM_DEPTH - 1));
    assign ks_data       = din_reg ^ rd_data;

endmodule

// File: hdl/rc4_page_descrambler_unit.sv
// Top level of the fixed-key RC4 page descrambler.
// Each accepted transaction carries one scrambled byte; the unit returns one byte XORed
// with the next RC4 keystream byte under the fixed 16-byte key. The keystream restarts
// after every byte marked last_of_page and at the first byte after reset: that byte first
// pays for the full key schedule (one index clear, 256 fill writes, 5 x 256 swap steps,
// one j clear). A byte within a page runs through the idle, dispatch and eight keystream
// steps before the next byte can be accepted, a step sequence set by the single 256x8
// permutation RAM with one read and one write port and registered read data: three
// dependent reads and two swap writes in sequence. One byte is in flight at a time;
// the result sits in an output register, so the next byte is accepted while the previous
// result is still waiting, and that byte holds just before its result load until the
// output slot drains.
`include "rc4_page_descrambler_unit_defines.svh"

module rc4_page_descrambler_unit (
    input  logic         clk,
    input  logic         rst_n,
    rc4pd_in_if.sink     in_ch,
    rc4pd_out_if.source  out_ch
);
    import rc4pd_pkg::*;

    ctrl_t      ctrl;
    dp_status_t status;
    logic       accept;
    logic       out_busy;
    byte_t      ks_data;
    byte_t      data_out_reg;
    logic       out_valid_reg;

    // Take a new byte at the idle step; the output slot is checked later, before the
    // result load.
    assign in_ch.ready = ctrl.in_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    // The slot stays occupied past this edge: hold the sequencer before the load.
    assign out_busy    = out_valid_reg && !out_ch.ready;

    rc4pd_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .out_busy (out_busy),
        .status   (status),
        .ctrl     (ctrl)
    );

    rc4pd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .accept       (accept),
        .data_in      (in_ch.data_in),
        .last_of_page (in_ch.last_of_page),
        .status       (status),
        .ks_data      (ks_data)
    );

    // Output register: load on the final step, drop when the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            data_out_reg <= ks_data;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = data_out_reg;

    // A stalled result stays valid and unchanged.
    `RC4PD_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data_out),
        "output transaction changed while stalled")
    // A result never overwrites one that has not been delivered.
    `RC4PD_ASSERT_IMP(a_no_overwrite, ctrl.out_load, !out_valid_reg,
        "result loaded over an undelivered result")
    // The permutation is never written while a new byte can be accepted.
    `RC4PD_ASSERT_IMP(a_no_write_when_ready, ctrl.wr_en, !in_ch.ready,
        "permutation written while input is ready")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the fixed-key RC4 page descrambler.
`timescale 1ns / 100ps

module tb_top;
    import rc4pd_pkg::*;

    localparam int     CLK_HALF         = 5;
    localparam int     RANDOM_BYTES     = 1650;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     HOLD_OFF_AT      = 500;
    localparam int     DRAIN_AT         = 1000;
    // Quiet cycles watched after the last result for stray transactions
    localparam int     TAIL_CYCLES      = 40;
    localparam longint RUN_LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        byte_t data;
        logic  last;
    } page_byte_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_t;

    // Directed bytes: field extremes, page ends and one-byte pages. None of the
    // keystream bytes is obvious by inspection, so the predictor checks them all.
    localparam int DIRECTED_ROWS = 16;
    localparam page_byte_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0},   // first byte after reset: key schedule runs first
        '{8'hFF, 1'b0},
        '{8'h55, 1'b0},
        '{8'hAA, 1'b0},
        '{8'h80, 1'b0},
        '{8'h7F, 1'b1},   // close the first page
        '{8'h00, 1'b1},   // one-byte page
        '{8'hFF, 1'b1},   // one-byte page, back to back with the previous one
        '{8'h01, 1'b0},
        '{8'hFE, 1'b0},
        '{8'h0F, 1'b0},
        '{8'hF0, 1'b1},
        '{8'hA5, 1'b1},   // one-byte page
        '{8'h5A, 1'b0},
        '{8'hC3, 1'b0},
        '{8'h3C, 1'b1}
    };

    logic clk;
    logic rst_n;

    rc4pd_in_if  in_bus ();
    rc4pd_out_if out_bus ();

    rc4_page_descrambler_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    // Predictor state: permutation, stream indices, pending restart
    byte_t keystream_perm [PERM_DEPTH];
    byte_t ks_i;
    byte_t ks_j;
    logic  restart_due = 1'b1;

    // Descrambled bytes still owed by the block, oldest first
    byte_t expected_plain [$];
    int    mismatch_cnt = 0;

    // Long receiver hold-off: the stimulus bumps the request count, the receiver
    // serves each request once
    int    hold_off_asks  = 0;
    int    hold_off_given = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Advance the keystream by one byte and return the descrambled byte. Rerun the
    // full key schedule first when a page boundary (or reset) lies behind us.
    function automatic byte_t descramble_next(byte_t cipher, logic page_end);
        byte_t      acc;
        byte_t      held;
        byte_t      si;
        byte_t      sj;
        perm_addr_t sum_idx;
        if (restart_due)
        begin
            for (int n = 0; n < PERM_DEPTH; n++)
                keystream_perm[n] = byte_t'(n);
            acc = '0;
            for (int n = 0; n < PERM_DEPTH; n++)
            begin
                held = keystream_perm[n];
                acc  = acc + held + SCRAMBLE_KEY[n % KEY_LEN];
                keystream_perm[n]   = keystream_perm[acc];
                keystream_perm[acc] = held;
            end
            ks_i = '0;
            ks_j = '0;
        end
        ks_i    = ks_i + 8'd1;
        si      = keystream_perm[ks_i];
        ks_j    = ks_j + si;
        sj      = keystream_perm[ks_j];
        keystream_perm[ks_i] = sj;
        keystream_perm[ks_j] = si;
        sum_idx = si + sj;
        restart_due = page_end;
        return cipher ^ keystream_perm[sum_idx];
    endfunction

    // Scoreboard: check the output transaction against the oldest expectation
    // first, then record the prediction for any input transaction of this edge.
    // Both sides are sampled at the rising edge, inputs having settled at the fall.
    always @(posedge clk)
    begin
        byte_t want;
        if (rst_n)
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_plain.size() == 0)
                begin
                    $display("%0t: data_out %02h arrived with nothing pending",
                             $time, out_bus.data_out);
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_plain.pop_front();
                    if (out_bus.data_out !== want)
                    begin
                        $display("%0t: data_out mismatch, expected %02h, actual %02h",
                                 $time, want, out_bus.data_out);
                        mismatch_cnt++;
                    end
                end
            end
            if (in_bus.valid && in_bus.ready)
                expected_plain.push_back(descramble_next(in_bus.data_in,
                                                         in_bus.last_of_page));
        end
    end

    // Hold one byte on the input channel until the block takes it. Valid stays
    // high afterwards, so a following offer_byte makes a back-to-back transaction.
    task automatic offer_byte(byte_t data, logic page_end);
        @(negedge clk);
        in_bus.valid        <= 1'b1;
        in_bus.data_in      <= data;
        in_bus.last_of_page <= page_end;
        do
            @(posedge clk);
        while (!in_bus.ready);
    endtask

    // Drop valid for a number of cycles and wiggle the idle payload meanwhile.
    task automatic pause_input(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_bus.valid        <= 1'b0;
            in_bus.data_in      <= byte_t'($urandom);
            in_bus.last_of_page <= 1'b0;
        end
    endtask

    // Receiver: cycle through stall patterns of random length, and serve each
    // long hold-off request by keeping ready low for a counted stretch.
    initial
    begin
        rx_mode_t rx_mode;
        int       phase_left;
        int       tick;
        out_bus.ready = 1'b0;
        rx_mode    = RX_OPEN;
        phase_left = 0;
        tick       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_given != hold_off_asks)
            begin
                hold_off_given = hold_off_asks;
                out_bus.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (phase_left == 0)
                begin
                    rx_mode    = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(8, 120);
                end
                phase_left--;
                tick++;
                case (rx_mode)
                    RX_OPEN:        out_bus.ready <= 1'b1;
                    RX_COIN:        out_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:      out_bus.ready <= ($urandom_range(0, 3) == 0);
                    RX_EVERY_THIRD: out_bus.ready <= (tick % 3 == 0);
                    default:        out_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus: reset, directed table, then random pages
    initial
    begin
        int    sent;
        int    page_len;
        int    page_pos;
        int    roll;
        int    burst_left;
        byte_t data;
        rst_n               = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.data_in      = '0;
        in_bus.last_of_page = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, offered back to back
        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_byte(DIRECTED[r].data, DIRECTED[r].last);

        // Random pages: mostly ordinary lengths, some tiny ones, and now and then
        // one long enough for the stream index to wrap
        sent       = 0;
        page_len   = 0;
        page_pos   = 0;
        burst_left = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (page_pos == page_len)
            begin
                roll = $urandom_range(0, 15);
                if (roll == 0)
                    page_len = 1;
                else if (roll < 3)
                    page_len = $urandom_range(2, 8);
                else if (roll == 3)
                    page_len = $urandom_range(257, 420);
                else
                    page_len = $urandom_range(16, 256);
                page_pos = 0;
            end

            if (sent == HOLD_OFF_AT)
            begin
                // Stall the receiver and keep offering so the block backs up
                hold_off_asks++;
                burst_left = 60;
            end
            else if (sent == DRAIN_AT)
            begin
                // Hold the sender until every result is back
                pause_input(1);
                while (expected_plain.size() != 0)
                    @(negedge clk);
                burst_left = 0;
            end

            if (burst_left == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    burst_left = $urandom_range(100, 250);
                else
                begin
                    pause_input($urandom_range(1, 14));
                    burst_left = $urandom_range(1, 30);
                end
            end
            burst_left--;

            data = byte_t'($urandom_range(0, 255));
            page_pos++;
            offer_byte(data, page_pos == page_len);
            sent++;
        end

        // Drain, then watch a while for stray results
        pause_input(1);
        while (expected_plain.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: rc4_page_descrambler_unit.f
+incdir+hdl
hdl/rc4pd_pkg.sv
hdl/rc4pd_ifs.sv
hdl/rc4pd_ram.sv
hdl/rc4pd_sequencer.sv
hdl/rc4pd_datapath.sv
hdl/rc4_page_descrambler_unit.sv
tb/sv/tb_top.sv
